@@ rtl/core/nnpo_pkg.sv @@
// nnpo_pkg: shared types, register codes and reset values for the path order unit
// no dependencies; imported by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package nnpo_pkg;

	localparam int MAX_POINTS_DEFAULT = 4096;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT    = 2'd1;

	localparam logic [16:0] SEARCH_RADIUS_RESET = 17'd4096;
	localparam logic [15:0] JUMP_LIMIT_RESET    = 16'd10000;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               first_point;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] path_x;
		logic signed [15:0] path_y;
		logic               stroke_start;
		logic               path_last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_item_t;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_TAKE_A,
		ST_TAKE_B,
		ST_TAKE_C
	} state_t;

	typedef enum logic [1:0] {
		RD_SCAN,
		RD_TAKE,
		RD_LAST
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    fetch_start;
		logic    scan_issue;
		logic    take_first;
		logic    take_latch;
		logic    commit;
		rd_sel_t rd_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic jump_ok;
		logic scan_last;
		logic pipe_empty;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/nnpo_ifs.sv @@
// nnpo_ifs: valid/ready channel interfaces for point items, path items and config writes
// depends on nnpo_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface nnpo_in_if;
	logic               valid;
	logic               ready;
	nnpo_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nnpo_out_if;
	logic                valid;
	logic                ready;
	nnpo_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nnpo_cfg_if;
	logic                valid;
	logic                ready;
	nnpo_pkg::cfg_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nnpo_ctrl.sv @@
// nnpo_ctrl: sequencer for loads, the nearest point scan and the slot take
// depends on nnpo_pkg; drives nnpo_dp through a command struct
`timescale 1ns / 1ps
`default_nettype none

module nnpo_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  wire                    in_mode,
	output logic                   in_ready,
	input  nnpo_pkg::dp_status_t   status,
	output nnpo_pkg::ctrl_cmd_t    cmd
);
	import nnpo_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_mode == MODE_FETCH && !status.rem_zero) begin
					state_next = status.jump_ok ? ST_SCAN : ST_TAKE_A;
				end
			end
			ST_SCAN: begin
				if (status.scan_last) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.pipe_empty) begin
					state_next = ST_TAKE_A;
				end
			end
			ST_TAKE_A: state_next = ST_TAKE_B;
			ST_TAKE_B: state_next = ST_TAKE_C;
			ST_TAKE_C: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.rd_sel      = RD_SCAN;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load        = (in_mode == MODE_LOAD);
					cmd.fetch_start = (in_mode == MODE_FETCH);
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
			end
			ST_DRAIN: begin
				cmd.rd_sel = RD_SCAN;
			end
			ST_TAKE_A: begin
				cmd.rd_sel     = RD_TAKE;
				cmd.take_first = 1'b1;
			end
			ST_TAKE_B: begin
				cmd.rd_sel     = RD_LAST;
				cmd.take_latch = 1'b1;
			end
			ST_TAKE_C: begin
				// hold the last-slot read until the output register frees up
				cmd.rd_sel = RD_LAST;
				cmd.commit = status.out_free;
			end
			default: begin
				cmd.rd_sel = RD_SCAN;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/nnpo_dp.sv @@
// nnpo_dp: point store, scan pipeline, best candidate, stroke state and output register
// depends on nnpo_pkg; commanded by nnpo_ctrl
`timescale 1ns / 1ps
`default_nettype none

module nnpo_dp #(
	parameter int MAX_POINTS = nnpo_pkg::MAX_POINTS_DEFAULT
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  nnpo_pkg::ctrl_cmd_t                   cmd,
	output nnpo_pkg::dp_status_t                  status,
	input  wire                                   cfg_we,
	input  wire [nnpo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [nnpo_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire signed [15:0]                     load_x,
	input  wire signed [15:0]                     load_y,
	input  wire                                   load_clear,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output nnpo_pkg::out_item_t                   out_item
);
	import nnpo_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

	// config registers
	logic [16:0] radius_q;
	logic [15:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= SEARCH_RADIUS_RESET;
			limit_q  <= JUMP_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEARCH_RADIUS: radius_q <= cfg_data;
				REG_JUMP_LIMIT:    limit_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// control state
	logic [CW-1:0] rem_q;
	logic [15:0]   jump_q;
	logic          open_q;
	logic [31:0]   cur_q;
	logic [IW-1:0] scan_cnt_q;
	logic          found_q;
	logic [32:0]   best_q;
	logic [IW-1:0] best_idx_q;
	logic [IW-1:0] take_idx_q;
	logic [31:0]   p_q;
	logic          out_valid_q;
	out_item_t     out_q;

	logic [CW-1:0] rem_m1;
	logic [CW-1:0] rem_eff;
	logic [IW-1:0] take_idx;

	assign rem_m1   = rem_q - CW'(1);
	assign rem_eff  = load_clear ? '0 : rem_q;
	assign take_idx = found_q ? best_idx_q : '0;

	// point store
	logic [31:0]   mem [MAX_POINTS];
	logic [31:0]   rdata_q;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_SCAN: raddr = scan_cnt_q;
			RD_TAKE: raddr = take_idx;
			RD_LAST: raddr = rem_m1[IW-1:0];
			default: raddr = scan_cnt_q;
		endcase
	end

	always_comb begin
		if (cmd.commit) begin
			we    = 1'b1;
			waddr = take_idx_q;
			wdata = rdata_q;
		end else begin
			we    = cmd.load && (rem_eff < CAP);
			waddr = rem_eff[IW-1:0];
			wdata = {load_y, load_x};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// scan pipeline: read, abs diff and window test, squares, sum and compare
	logic          v_s1, v_s2, v_s3;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3;
	logic [15:0]   ax_s2, ay_s2;
	logic          qual_s2, qual_s3;
	logic [31:0]   sqx_s3, sqy_s3;

	logic signed [16:0] dx, dy;
	logic signed [16:0] adx, ady;
	logic [15:0]        ax, ay;
	logic [32:0]        d2;

	always_comb begin
		dx  = {rdata_q[15], rdata_q[15:0]} - {cur_q[15], cur_q[15:0]};
		dy  = {rdata_q[31], rdata_q[31:16]} - {cur_q[31], cur_q[31:16]};
		adx = dx[16] ? -dx : dx;
		ady = dy[16] ? -dy : dy;
		ax  = adx[15:0];
		ay  = ady[15:0];
		d2  = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_cnt_q;
		idx_s2  <= idx_s1;
		ax_s2   <= ax;
		ay_s2   <= ay;
		qual_s2 <= ({1'b0, ax} < radius_q) && ({1'b0, ay} < radius_q);
		idx_s3  <= idx_s2;
		qual_s3 <= qual_s2;
		sqx_s3  <= ax_s2 * ax_s2;
		sqy_s3  <= ay_s2 * ay_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			jump_q      <= '0;
			open_q      <= 1'b0;
			cur_q       <= '0;
			scan_cnt_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (load_clear) begin
					jump_q <= '0;
					open_q <= 1'b0;
				end
				if (rem_eff < CAP) begin
					rem_q <= rem_eff + CW'(1);
				end else begin
					rem_q <= rem_eff;
				end
			end
			if (cmd.fetch_start) begin
				scan_cnt_q <= '0;
				found_q    <= 1'b0;
			end else if (cmd.scan_issue) begin
				scan_cnt_q <= scan_cnt_q + IW'(1);
			end
			// later slots win ties, hence the less-or-equal
			if (v_s3 && qual_s3 && d2 != '0 && (!found_q || d2 <= best_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.commit) begin
				rem_q  <= rem_m1;
				cur_q  <= p_q;
				open_q <= 1'b1;
				jump_q <= found_q ? jump_q + 16'd1 : '0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && qual_s3 && d2 != '0 && (!found_q || d2 <= best_q)) begin
			best_q     <= d2;
			best_idx_q <= idx_s3;
		end
		if (cmd.take_first) begin
			take_idx_q <= take_idx;
		end
		if (cmd.take_latch) begin
			p_q <= rdata_q;
		end
		if (cmd.commit) begin
			out_q.path_x       <= p_q[15:0];
			out_q.path_y       <= p_q[31:16];
			out_q.stroke_start <= !found_q;
			out_q.path_last    <= (rem_q == CW'(1));
		end
	end

	assign status.rem_zero   = (rem_q == '0);
	assign status.jump_ok    = open_q && (jump_q < limit_q);
	assign status.scan_last  = (scan_cnt_q == rem_m1[IW-1:0]);
	assign status.pipe_empty = !(v_s1 || v_s2 || v_s3);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/nearest_neighbor_path_order_unit.sv @@
// nearest_neighbor_path_order_unit: greedy nearest point path ordering over a point store
// sequence: a load item is stored as it is accepted; a stroke-start fetch runs the take states;
// a neighbor fetch first scans the remaining slots, one store memory port read per cycle
// throughput: one item at a time; a finished path item waits in the output register
// reset: arst_n clears counts, stroke state and config to defaults; store contents are
// undefined until loaded and get no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_path_order_unit #(
	parameter int MAX_POINTS = nnpo_pkg::MAX_POINTS_DEFAULT
) (
	input  wire        clk,
	input  wire        arst_n,
	nnpo_in_if.sink    points,
	nnpo_out_if.source path,
	nnpo_cfg_if.sink   cfg
);
	import nnpo_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       in_ready;

	assign points.ready = in_ready;
	assign cfg.ready    = 1'b1;

	nnpo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.in_mode  (points.payload.mode),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	nnpo_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.payload.index),
		.cfg_data   (cfg.payload.data),
		.load_x     (points.payload.point_x),
		.load_y     (points.payload.point_y),
		.load_clear (points.payload.first_point),
		.out_valid  (path.valid),
		.out_ready  (path.ready),
		.out_item   (path.payload)
	);

endmodule

`default_nettype wire
